/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the push-out block.
// Each macro wraps one clocked implication with an asynchronous reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AOP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("push-out check failed");

// Next-cycle implication.
`define AOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("push-out check failed");

`endif

/* rtl/aop_pkg.sv */
// Shared types and constants of the box push-out block.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package aop_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_X   = 3'd0,
    REG_HALF_Y   = 3'd1,
    REG_HALF_Z   = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUTCOME_FREE     = 2'd0,
    OUTCOME_RESTORED = 2'd1,
    OUTCOME_SOLID    = 2'd2
  } outcome_e;

  // Candidate directions in search order within one round.
  typedef enum logic [2:0] {
    DIR_XP = 3'd0,
    DIR_XN = 3'd1,
    DIR_ZP = 3'd2,
    DIR_ZN = 3'd3,
    DIR_YP = 3'd4,
    DIR_YN = 3'd5
  } dir_e;

  typedef enum logic {
    RES_START = 1'b0,
    RES_CAND  = 1'b1
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     check;
    logic     gen;
    logic     gen_last;
    dir_e     dir;
    logic     capture;
    res_sel_e res_sel;
    outcome_e outcome;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic solid;
    logic start_hit;
    logic cand_valid;
    logic cand_free;
    logic cand_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/aop_if.sv */
// Request, result and configuration channels of the box push-out block.
// Depends on aop_pkg for default widths.
`default_nettype none

interface aop_req_if #(
  parameter int unsigned COORD_WIDTH = aop_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mover_solid;
  logic signed [COORD_WIDTH-1:0] mover_x;
  logic signed [COORD_WIDTH-1:0] mover_y;
  logic signed [COORD_WIDTH-1:0] mover_z;
  logic        [COORD_WIDTH-2:0] mover_half_x;
  logic        [COORD_WIDTH-2:0] mover_half_y;
  logic        [COORD_WIDTH-2:0] mover_half_z;
  logic signed [COORD_WIDTH-1:0] static_pos_x;
  logic signed [COORD_WIDTH-1:0] static_pos_y;
  logic signed [COORD_WIDTH-1:0] static_pos_z;

  modport source (
    output valid, mover_solid, mover_x, mover_y, mover_z,
    output mover_half_x, mover_half_y, mover_half_z,
    output static_pos_x, static_pos_y, static_pos_z,
    input  ready
  );
  modport sink (
    input  valid, mover_solid, mover_x, mover_y, mover_z,
    input  mover_half_x, mover_half_y, mover_half_z,
    input  static_pos_x, static_pos_y, static_pos_z,
    output ready
  );
endinterface

interface aop_res_if #(
  parameter int unsigned COORD_WIDTH = aop_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_x;
  logic signed [COORD_WIDTH-1:0] new_y;
  logic signed [COORD_WIDTH-1:0] new_z;
  logic        [1:0]             outcome;

  modport source (output valid, new_x, new_y, new_z, outcome, input ready);
  modport sink (input valid, new_x, new_y, new_z, outcome, output ready);
endinterface

interface aop_cfg_if #(
  parameter int unsigned COORD_WIDTH = aop_pkg::COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [aop_pkg::CFG_IDX_W-1:0]  index;
  logic [COORD_WIDTH-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/aabb_overlap_push_out.sv */
// Box push-out: a moving box that overlaps the static box is pushed to the first
// free position along +x, -x, +z, -z, +y, -y in growing steps of 0.1.
// A solid or non-overlapping mover is answered from the start check; otherwise the
// search runs until a candidate is free or all 294 candidates fail (defaults).
// One tester checks one candidate per cycle; the block is ready for the next request
// in the cycle after the result is loaded. Async reset.
`default_nettype none

module aabb_overlap_push_out #(
  parameter int unsigned COORD_WIDTH = aop_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = aop_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aop_req_if.sink   req_i,
  aop_res_if.source res_o,
  aop_cfg_if.sink   cfg_i
);

  aop_pkg::cmd_t        cmd;
  aop_pkg::status_t     status;
  logic [FRAC_BITS+2:0] amount;

  assign cfg_i.ready = 1'b1;

  aop_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .amount_o    (amount)
  );

  aop_dp #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .amount_i       (amount),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .mover_solid_i  (req_i.mover_solid),
    .mover_x_i      (req_i.mover_x),
    .mover_y_i      (req_i.mover_y),
    .mover_z_i      (req_i.mover_z),
    .mover_half_x_i (req_i.mover_half_x),
    .mover_half_y_i (req_i.mover_half_y),
    .mover_half_z_i (req_i.mover_half_z),
    .static_pos_x_i (req_i.static_pos_x),
    .static_pos_y_i (req_i.static_pos_y),
    .static_pos_z_i (req_i.static_pos_z),
    .status_o       (status),
    .new_x_o        (res_o.new_x),
    .new_y_o        (res_o.new_y),
    .new_z_o        (res_o.new_z),
    .outcome_o      (res_o.outcome)
  );

endmodule

`default_nettype wire

/* rtl/aop_ctrl.sv */
// Sequencer of the push-out search: handshakes, round and direction counters.
// Depends on aop_pkg for the command and status structs.
`default_nettype none

module aop_ctrl #(
  parameter int unsigned FRAC_BITS = aop_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  input  aop_pkg::status_t        status_i,
  output aop_pkg::cmd_t           cmd_o,
  output logic [FRAC_BITS+2:0]    amount_o
);

  localparam int unsigned AMT_W = FRAC_BITS + 3;
  // 0.1 rounded to nearest and 5.0, both in the coordinate fixed-point format.
  localparam logic [AMT_W-1:0] STEP  = AMT_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [AMT_W-1:0] LIMIT = AMT_W'(5 * (1 << FRAC_BITS));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [AMT_W-1:0]  amount_q, amount_d;
  aop_pkg::dir_e     dir_q, dir_d;
  logic              issue_q, issue_d;
  logic              out_valid_q, out_valid_d;
  logic [AMT_W-1:0]  amount_next;
  logic              last_issue;

  assign amount_next = amount_q + STEP;
  assign last_issue  = (dir_q == aop_pkg::DIR_YN) && (amount_next >= LIMIT);

  always_comb begin
    state_d     = state_q;
    amount_d    = amount_q;
    dir_d       = dir_q;
    issue_d     = issue_q;
    out_valid_d = out_valid_q && !res_ready_i;
    cmd_o       = '0;
    cmd_o.dir   = dir_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check   = 1'b1;
        cmd_o.res_sel = aop_pkg::RES_START;
        if (status_i.solid) begin
          cmd_o.capture = 1'b1;
          cmd_o.outcome = aop_pkg::OUTCOME_SOLID;
          state_d       = ST_DONE;
        end else if (!status_i.start_hit) begin
          cmd_o.capture = 1'b1;
          cmd_o.outcome = aop_pkg::OUTCOME_FREE;
          state_d       = ST_DONE;
        end else begin
          amount_d = STEP;
          dir_d    = aop_pkg::DIR_XP;
          issue_d  = 1'b1;
          state_d  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // One candidate is generated per cycle; the previous one is tested alongside.
        if (status_i.cand_valid && status_i.cand_free) begin
          cmd_o.capture = 1'b1;
          cmd_o.res_sel = aop_pkg::RES_CAND;
          cmd_o.outcome = aop_pkg::OUTCOME_FREE;
          issue_d       = 1'b0;
          state_d       = ST_DONE;
        end else if (status_i.cand_valid && status_i.cand_last) begin
          cmd_o.capture = 1'b1;
          cmd_o.res_sel = aop_pkg::RES_START;
          cmd_o.outcome = aop_pkg::OUTCOME_RESTORED;
          issue_d       = 1'b0;
          state_d       = ST_DONE;
        end else if (issue_q) begin
          cmd_o.gen      = 1'b1;
          cmd_o.gen_last = last_issue;
          if (dir_q == aop_pkg::DIR_YN) begin
            dir_d    = aop_pkg::DIR_XP;
            amount_d = amount_next;
          end else begin
            dir_d = aop_pkg::dir_e'(dir_q + 3'd1);
          end
          if (last_issue) begin
            issue_d = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      amount_q    <= '0;
      dir_q       <= aop_pkg::DIR_XP;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      amount_q    <= amount_d;
      dir_q       <= dir_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign amount_o    = amount_q;

endmodule

`default_nettype wire

/* rtl/aop_dp.sv */
// Datapath of the push-out block: static box registers, candidate generator,
// single-axis overlap tester and result registers. Depends on aop_pkg.
`default_nettype none

module aop_dp #(
  parameter int unsigned COORD_WIDTH = aop_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = aop_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aop_pkg::cmd_t                     cmd_i,
  input  logic        [FRAC_BITS+2:0]       amount_i,
  input  logic                              cfg_we_i,
  input  logic        [aop_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [COORD_WIDTH-1:0]     cfg_data_i,
  input  logic                              mover_solid_i,
  input  logic signed [COORD_WIDTH-1:0]     mover_x_i,
  input  logic signed [COORD_WIDTH-1:0]     mover_y_i,
  input  logic signed [COORD_WIDTH-1:0]     mover_z_i,
  input  logic        [COORD_WIDTH-2:0]     mover_half_x_i,
  input  logic        [COORD_WIDTH-2:0]     mover_half_y_i,
  input  logic        [COORD_WIDTH-2:0]     mover_half_z_i,
  input  logic signed [COORD_WIDTH-1:0]     static_pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]     static_pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]     static_pos_z_i,
  output aop_pkg::status_t                  status_o,
  output logic signed [COORD_WIDTH-1:0]     new_x_o,
  output logic signed [COORD_WIDTH-1:0]     new_y_o,
  output logic signed [COORD_WIDTH-1:0]     new_z_o,
  output logic        [1:0]                 outcome_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned HW    = CW - 1;
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned DW    = CW + 2;
  localparam int unsigned AMT_W = FRAC_BITS + 3;
  localparam int unsigned EXT_W = ((CW > AMT_W) ? CW : AMT_W) + 2;

  localparam logic        [HW-1:0]    HALF_ONE = HW'(1) << FRAC_BITS;
  localparam logic signed [EXT_W-1:0] CMAX = EXT_W'((longint'(1) <<< (CW - 1)) - longint'(1));
  localparam logic signed [EXT_W-1:0] CMIN = EXT_W'(-CMAX - 1);

  // Axis order of the reference frame: 0 = x, 1 = y, 2 = z.
  logic        [HW-1:0] half_q  [3];
  logic signed [CW-1:0] off_q   [3];
  logic signed [CW-1:0] start_q [3];
  logic signed [SW-1:0] scen_q  [3];
  logic        [CW-1:0] hsum_q  [3];
  logic signed [CW-1:0] res_q   [3];
  logic signed [CW-1:0] out_q   [3];
  logic                 solid_q;
  logic [2:0]           start_hit_q;
  logic [2:0]           start_hit_now;
  logic signed [CW-1:0] cand_q;
  aop_pkg::dir_e        cand_dir_q;
  logic                 cand_valid_q;
  logic                 cand_last_q;
  aop_pkg::outcome_e    res_outcome_q;
  aop_pkg::outcome_e    out_outcome_q;

  logic [1:0]             gen_ax;
  logic [1:0]             cand_ax;
  logic signed [EXT_W-1:0] gen_sum;
  logic signed [EXT_W-1:0] gen_sat;
  logic                   cand_axis_hit;
  logic [2:0]             cand_hit_vec;

  function automatic logic [1:0] dir_axis(aop_pkg::dir_e dir);
    logic [1:0] ax;
    case (dir)
      aop_pkg::DIR_XP, aop_pkg::DIR_XN: ax = 2'd0;
      aop_pkg::DIR_YP, aop_pkg::DIR_YN: ax = 2'd1;
      default:                          ax = 2'd2;
    endcase
    return ax;
  endfunction

  // Intervals touch or overlap when the centre distance is at most the half-size sum.
  function automatic logic axis_hit(logic signed [SW-1:0] c, logic signed [CW-1:0] p,
                                    logic [CW-1:0] h);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] hh;
    d  = DW'(c) - DW'(p);
    hh = $signed(DW'(h));
    return (d <= hh) && (d >= -hh);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= HALF_ONE;
      half_q[1] <= HALF_ONE;
      half_q[2] <= HALF_ONE;
      off_q[0]  <= '0;
      off_q[1]  <= '0;
      off_q[2]  <= '0;
    end else if (cfg_we_i) begin
      unique case (aop_pkg::cfg_reg_e'(cfg_idx_i))
        aop_pkg::REG_HALF_X:   half_q[0] <= cfg_data_i[HW-1:0];
        aop_pkg::REG_HALF_Y:   half_q[1] <= cfg_data_i[HW-1:0];
        aop_pkg::REG_HALF_Z:   half_q[2] <= cfg_data_i[HW-1:0];
        aop_pkg::REG_OFFSET_X: off_q[0]  <= $signed(cfg_data_i);
        aop_pkg::REG_OFFSET_Y: off_q[1]  <= $signed(cfg_data_i);
        aop_pkg::REG_OFFSET_Z: off_q[2]  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      start_hit_now[i] = axis_hit(scen_q[i], start_q[i], hsum_q[i]);
    end
  end

  // Candidate generator: start coordinate moved by the amount, saturated.
  assign gen_ax = dir_axis(cmd_i.dir);

  always_comb begin
    if (cmd_i.dir == aop_pkg::DIR_XN || cmd_i.dir == aop_pkg::DIR_YN ||
        cmd_i.dir == aop_pkg::DIR_ZN) begin
      gen_sum = EXT_W'(start_q[gen_ax]) - $signed(EXT_W'(amount_i));
    end else begin
      gen_sum = EXT_W'(start_q[gen_ax]) + $signed(EXT_W'(amount_i));
    end
    if (gen_sum > CMAX) begin
      gen_sat = CMAX;
    end else if (gen_sum < CMIN) begin
      gen_sat = CMIN;
    end else begin
      gen_sat = gen_sum;
    end
  end

  // Only the moved axis is retested; the other two keep their start result.
  assign cand_ax       = dir_axis(cand_dir_q);
  assign cand_axis_hit = axis_hit(scen_q[cand_ax], cand_q, hsum_q[cand_ax]);

  always_comb begin
    cand_hit_vec          = start_hit_q;
    cand_hit_vec[cand_ax] = cand_axis_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
      cand_last_q  <= 1'b0;
    end else begin
      cand_valid_q <= cmd_i.gen;
      cand_last_q  <= cmd_i.gen && cmd_i.gen_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      solid_q    <= mover_solid_i;
      start_q[0] <= mover_x_i;
      start_q[1] <= mover_y_i;
      start_q[2] <= mover_z_i;
      scen_q[0]  <= SW'(static_pos_x_i) + SW'(off_q[0]);
      scen_q[1]  <= SW'(static_pos_y_i) + SW'(off_q[1]);
      scen_q[2]  <= SW'(static_pos_z_i) + SW'(off_q[2]);
      hsum_q[0]  <= CW'(half_q[0]) + CW'(mover_half_x_i);
      hsum_q[1]  <= CW'(half_q[1]) + CW'(mover_half_y_i);
      hsum_q[2]  <= CW'(half_q[2]) + CW'(mover_half_z_i);
    end
    if (cmd_i.check) begin
      start_hit_q <= start_hit_now;
    end
    if (cmd_i.gen) begin
      cand_q     <= gen_sat[CW-1:0];
      cand_dir_q <= cmd_i.dir;
    end
    if (cmd_i.capture) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd_i.res_sel == aop_pkg::RES_CAND && cand_ax == 2'(i)) begin
          res_q[i] <= cand_q;
        end else begin
          res_q[i] <= start_q[i];
        end
      end
      res_outcome_q <= cmd_i.outcome;
    end
    if (cmd_i.out_load) begin
      out_q[0]      <= res_q[0];
      out_q[1]      <= res_q[1];
      out_q[2]      <= res_q[2];
      out_outcome_q <= res_outcome_q;
    end
  end

  assign status_o.solid      = solid_q;
  assign status_o.start_hit  = &start_hit_now;
  assign status_o.cand_valid = cand_valid_q;
  assign status_o.cand_free  = cand_valid_q && !(&cand_hit_vec);
  assign status_o.cand_last  = cand_last_q;

  assign new_x_o   = out_q[0];
  assign new_y_o   = out_q[1];
  assign new_z_o   = out_q[2];
  assign outcome_o = out_outcome_q;

endmodule

`default_nettype wire

/* rtl/aop_checker.sv */
// Port-level checks of the push-out block, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module aop_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic res_valid_i,
  input logic res_ready_i
);

  logic req_fire;
  logic res_fire;
  logic new_res;
  logic pend_q;
  logic res_valid_prev_q;
  logic res_fire_prev_q;

  assign req_fire = req_valid_i && req_ready_i;
  assign res_fire = res_valid_i && res_ready_i;
  // A result is new when valid rises or follows a taken result.
  assign new_res  = res_valid_i && (!res_valid_prev_q || res_fire_prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q           <= 1'b0;
      res_valid_prev_q <= 1'b0;
      res_fire_prev_q  <= 1'b0;
    end else begin
      pend_q           <= req_fire ? 1'b1 : (new_res ? 1'b0 : pend_q);
      res_valid_prev_q <= res_valid_i;
      res_fire_prev_q  <= res_fire;
    end
  end

  `AOP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)
  `AOP_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_fire, !req_ready_i)
  `AOP_ASSERT_IMPL(a_res_has_req, clk_i, rst_ni, new_res, pend_q)
  `AOP_ASSERT_IMPL(a_one_in_flight, clk_i, rst_ni, req_fire, !pend_q || new_res)

endmodule

bind aabb_overlap_push_out aop_checker u_aop_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready)
);

`default_nettype wire

/* verif/aabb_overlap_push_out_test.sv */
// Self-checking testbench of the box push-out block: drives requests and
// configuration writes, predicts each result and checks it in order.
// Depends on aop_pkg, the channel interfaces in aop_if.sv and the block itself.
module aabb_overlap_push_out_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_W = aop_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FRAC    = aop_pkg::FRAC_BITS_DEF;

  localparam longint ONE_FX    = longint'(1) << FRAC;
  localparam longint STEP_FX   = (ONE_FX + 5) / 10;
  localparam longint LIMIT_FX  = 5 * ONE_FX;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint HALF_MAX  = COORD_MAX;
  localparam longint SPAN_CAP  = longint'(1) << 30;

  localparam logic [aop_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [aop_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                      solid;
    logic signed [COORD_W-1:0] mx, my, mz;
    logic        [COORD_W-2:0] hx, hy, hz;
    logic signed [COORD_W-1:0] px, py, pz;
  } push_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    aop_pkg::outcome_e         outcome;
  } push_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  aop_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
  aop_res_if #(.COORD_WIDTH(COORD_W)) res_ch ();
  aop_cfg_if #(.COORD_WIDTH(COORD_W)) cfg_ch ();

  aabb_overlap_push_out #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the static box registers, indexed x, y, z.
  logic        [COORD_W-2:0] cfg_half [3];
  logic signed [COORD_W-1:0] cfg_off  [3];

  push_req_t pending_q [$];
  push_res_t expected_q [$];
  int        outstanding   = 0;
  int        mismatch_count = 0;
  int        stuck_cycles  = 0;
  bit        req_taken     = 1'b0;
  bit        idle_on       = 1'b1;
  bit        hold_request  = 1'b0;
  int        send_gap      = 0;
  int        recv_stall    = 0;
  int        hold_left     = 0;

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Closed intervals: touching counts as overlap.
  function automatic bit axis_touch(longint a, longint ha, longint b, longint hb);
    if (a > b) return !(a - ha > b + hb);
    return !(b - hb > a + ha);
  endfunction

  function automatic bit boxes_touch(longint c[3], longint hc[3], longint p[3], longint hp[3]);
    return axis_touch(c[0], hc[0], p[0], hp[0]) && axis_touch(c[2], hc[2], p[2], hp[2]) &&
           axis_touch(c[1], hc[1], p[1], hp[1]);
  endfunction

  function automatic push_res_t resolve_push(push_req_t it);
    longint    start [3];
    longint    hp    [3];
    longint    sc    [3];
    longint    hs    [3];
    longint    cand  [3];
    longint    amount;
    int        axis;
    bit        found;
    push_res_t r;
    start[0] = longint'(it.mx);
    start[1] = longint'(it.my);
    start[2] = longint'(it.mz);
    hp[0] = longint'(it.hx);
    hp[1] = longint'(it.hy);
    hp[2] = longint'(it.hz);
    sc[0] = longint'(it.px) + longint'(cfg_off[0]);
    sc[1] = longint'(it.py) + longint'(cfg_off[1]);
    sc[2] = longint'(it.pz) + longint'(cfg_off[2]);
    for (int i = 0; i < 3; i++) hs[i] = longint'(cfg_half[i]);
    cand  = start;
    found = 1'b0;
    r.outcome = aop_pkg::OUTCOME_FREE;
    if (it.solid) begin
      r.outcome = aop_pkg::OUTCOME_SOLID;
    end else if (boxes_touch(sc, hs, start, hp)) begin
      // Each round tries x, then z, then y, positive direction first.
      for (amount = STEP_FX; amount < LIMIT_FX && !found; amount += STEP_FX) begin
        for (int a = 0; a < 3 && !found; a++) begin
          for (int sg = 0; sg < 2 && !found; sg++) begin
            axis = (a == 0) ? 0 : ((a == 1) ? 2 : 1);
            cand = start;
            cand[axis] = clamp_coord((sg == 0) ? start[axis] + amount : start[axis] - amount);
            found = !boxes_touch(sc, hs, cand, hp);
          end
        end
      end
      if (!found) begin
        cand = start;
        r.outcome = aop_pkg::OUTCOME_RESTORED;
      end
    end
    r.x = cand[0][COORD_W-1:0];
    r.y = cand[1][COORD_W-1:0];
    r.z = cand[2][COORD_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic push_req_t make_push(longint solid, longint mx, longint my, longint mz,
                                          longint hx, longint hy, longint hz,
                                          longint px, longint py, longint pz);
    push_req_t it;
    it.solid = solid[0];
    it.mx = mx[COORD_W-1:0];
    it.my = my[COORD_W-1:0];
    it.mz = mz[COORD_W-1:0];
    it.hx = hx[COORD_W-2:0];
    it.hy = hy[COORD_W-2:0];
    it.hz = hz[COORD_W-2:0];
    it.px = px[COORD_W-1:0];
    it.py = py[COORD_W-1:0];
    it.pz = pz[COORD_W-1:0];
    return it;
  endfunction

  // Mostly movers placed around the static box so that the search runs, with
  // some solid ones, some near the edges of the range and some pure noise.
  function automatic push_req_t random_push();
    push_req_t it;
    int        r;
    bit        edge_case;
    longint    base  [3];
    longint    hp    [3];
    longint    mover [3];
    longint    span;
    longint    d;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it.solid = 1'($urandom);
      it.mx = $urandom;
      it.my = $urandom;
      it.mz = $urandom;
      it.hx = (COORD_W-1)'($urandom);
      it.hy = (COORD_W-1)'($urandom);
      it.hz = (COORD_W-1)'($urandom);
      it.px = $urandom;
      it.py = $urandom;
      it.pz = $urandom;
      return it;
    end
    edge_case = (r >= 20 && r < 30);
    for (int a = 0; a < 3; a++) begin
      if (edge_case)
        base[a] = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 8 << FRAC)
                                       : COORD_MIN + $urandom_range(0, 8 << FRAC);
      else
        base[a] = longint'($urandom_range(0, 32'd8388608)) - 4194304;
      hp[a] = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 12 << FRAC))
                                          : longint'($urandom_range(0, 2 << FRAC));
      if ($urandom_range(0, 7) == 0) begin
        d = longint'(cfg_half[a]) + hp[a];
        if ($urandom_range(0, 1)) d = -d;
      end else begin
        span = longint'(cfg_half[a]) + hp[a] + ONE_FX / 2;
        if (span > SPAN_CAP) span = SPAN_CAP;
        d = longint'($urandom_range(0, 32'(2 * span))) - span;
      end
      mover[a] = clamp_coord(base[a] + longint'(cfg_off[a]) + d);
    end
    return make_push(longint'(r < 20), mover[0], mover[1], mover[2], hp[0], hp[1], hp[2],
                     base[0], base[1], base[2]);
  endfunction

  task automatic queue_push(push_req_t it);
    pending_q.push_back(it);
    outstanding++;
  endtask

  // Leaves valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [aop_pkg::CFG_IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic run_phase(input logic [COORD_W-1:0] half_x, half_y, half_z,
                           input logic [COORD_W-1:0] off_x, off_y, off_z,
                           input int n_items, input bit gaps, input bit hold);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(aop_pkg::REG_HALF_X, half_x);
    write_reg(aop_pkg::REG_HALF_Y, half_y);
    write_reg(aop_pkg::REG_HALF_Z, half_z);
    write_reg(aop_pkg::REG_OFFSET_X, off_x);
    write_reg(aop_pkg::REG_OFFSET_Y, off_y);
    write_reg(aop_pkg::REG_OFFSET_Z, off_z);
    write_reg(REG_SPARE_HI, $urandom);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    idle_on      = gaps;
    hold_request = hold;
    repeat (n_items) queue_push(random_push());
    wait (outstanding == 0);
  endtask

  // Request driver: a new request, or a gap, once the current one is taken.
  always @(negedge clk_i) begin
    push_req_t nxt;
    if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        req_ch.mover_solid  <= nxt.solid;
        req_ch.mover_x      <= nxt.mx;
        req_ch.mover_y      <= nxt.my;
        req_ch.mover_z      <= nxt.mz;
        req_ch.mover_half_x <= nxt.hx;
        req_ch.mover_half_y <= nxt.hy;
        req_ch.mover_half_z <= nxt.hz;
        req_ch.static_pos_x <= nxt.px;
        req_ch.static_pos_y <= nxt.py;
        req_ch.static_pos_z <= nxt.pz;
        req_ch.valid        <= 1'b1;
        send_gap = pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with random stalls and one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      res_ch.ready <= 1'b0;
      recv_stall--;
    end else begin
      res_ch.ready <= 1'b1;
      recv_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    push_req_t got;
    push_res_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          aop_pkg::REG_HALF_X:   cfg_half[0] = cfg_ch.data[COORD_W-2:0];
          aop_pkg::REG_HALF_Y:   cfg_half[1] = cfg_ch.data[COORD_W-2:0];
          aop_pkg::REG_HALF_Z:   cfg_half[2] = cfg_ch.data[COORD_W-2:0];
          aop_pkg::REG_OFFSET_X: cfg_off[0]  = cfg_ch.data;
          aop_pkg::REG_OFFSET_Y: cfg_off[1]  = cfg_ch.data;
          aop_pkg::REG_OFFSET_Z: cfg_off[2]  = cfg_ch.data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        req_taken = 1'b1;
        got.solid = req_ch.mover_solid;
        got.mx = req_ch.mover_x;
        got.my = req_ch.mover_y;
        got.mz = req_ch.mover_z;
        got.hx = req_ch.mover_half_x;
        got.hy = req_ch.mover_half_y;
        got.hz = req_ch.mover_half_z;
        got.px = req_ch.static_pos_x;
        got.py = req_ch.static_pos_y;
        got.pz = req_ch.static_pos_z;
        expected_q.push_back(resolve_push(got));
      end
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: mismatch: expected no result, actual x=%0d y=%0d z=%0d outcome=%0d",
                   $time, res_ch.new_x, res_ch.new_y, res_ch.new_z, res_ch.outcome);
        end else begin
          want = expected_q.pop_front();
          outstanding--;
          if (res_ch.new_x !== want.x || res_ch.new_y !== want.y ||
              res_ch.new_z !== want.z || res_ch.outcome !== want.outcome) begin
            mismatch_count++;
            $display("%0t: mismatch: expected x=%0d y=%0d z=%0d outcome=%0d", $time,
                     want.x, want.y, want.z, want.outcome);
            $display("%0t:           actual   x=%0d y=%0d z=%0d outcome=%0d", $time,
                     res_ch.new_x, res_ch.new_y, res_ch.new_z, res_ch.outcome);
          end
        end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mover_solid  = 1'b0;
    req_ch.mover_x      = '0;
    req_ch.mover_y      = '0;
    req_ch.mover_z      = '0;
    req_ch.mover_half_x = '0;
    req_ch.mover_half_y = '0;
    req_ch.mover_half_z = '0;
    req_ch.static_pos_x = '0;
    req_ch.static_pos_y = '0;
    req_ch.static_pos_z = '0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    for (int i = 0; i < 3; i++) begin
      cfg_half[i] = ONE_FX[COORD_W-2:0];
      cfg_off[i]  = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the static box at its reset size and offset.
    queue_push(make_push(0, 0, 0, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2, 0, 0, 0));
    queue_push(make_push(1, 0, 0, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2, 0, 0, 0));
    queue_push(make_push(0, 10 * ONE_FX, 0, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2, 0, 0, 0));
    // Touching faces still count as overlap; one LSB further apart is free.
    queue_push(make_push(0, 3 * ONE_FX / 2, 0, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2,
                         0, 0, 0));
    queue_push(make_push(0, 3 * ONE_FX / 2 + 1, 0, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2,
                         0, 0, 0));
    queue_push(make_push(0, 0, -3 * ONE_FX / 2, 0, ONE_FX / 2, ONE_FX / 2, ONE_FX / 2,
                         0, 0, 0));
    // Too large to be pushed free within the search: the start comes back.
    queue_push(make_push(0, 0, 0, 0, 10 * ONE_FX, 10 * ONE_FX, 10 * ONE_FX, 0, 0, 0));
    queue_push(make_push(0, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0, 0));
    // Candidates beyond the coordinate range saturate.
    queue_push(make_push(0, COORD_MAX, COORD_MAX, COORD_MAX, ONE_FX / 2, ONE_FX / 2,
                         ONE_FX / 2, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_push(make_push(0, COORD_MIN, COORD_MIN, COORD_MIN, ONE_FX / 2, ONE_FX / 2,
                         ONE_FX / 2, COORD_MIN, COORD_MIN, COORD_MIN));
    queue_push(make_push(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // One direction of each axis frees the mover first.
    queue_push(make_push(0, -58982, 0, 0, ONE_FX / 20, ONE_FX / 20, ONE_FX / 20, 0, 0, 0));
    queue_push(make_push(0, 0, 0, 62259, 10 * ONE_FX, ONE_FX / 10, ONE_FX / 10, 0, 0, 0));
    queue_push(make_push(0, 0, 0, -62259, 10 * ONE_FX, ONE_FX / 10, ONE_FX / 10, 0, 0, 0));
    queue_push(make_push(0, 0, 62259, 0, 10 * ONE_FX, ONE_FX / 10, 10 * ONE_FX, 0, 0, 0));
    queue_push(make_push(0, 0, -62259, 0, 10 * ONE_FX, ONE_FX / 10, 10 * ONE_FX, 0, 0, 0));
    queue_push(make_push(1, COORD_MIN, COORD_MIN, COORD_MIN, HALF_MAX, HALF_MAX, HALF_MAX,
                         COORD_MIN, COORD_MIN, COORD_MIN));
    queue_push(make_push(0, COORD_MAX, COORD_MIN, COORD_MAX, HALF_MAX, 0, HALF_MAX,
                         COORD_MIN, COORD_MAX, COORD_MIN));
    queue_push(make_push(0, COORD_MAX, 0, 0, ONE_FX, ONE_FX, ONE_FX, COORD_MIN, 0, 0));
    wait (outstanding == 0);

    run_phase(32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
              32'h0000_4000, 32'hFFFF_8000, 32'h0001_0000, 150, 1'b1, 1'b1);
    run_phase(32'h0, 32'h0, 32'h0, $urandom, $urandom, $urandom, 100, 1'b1, 1'b0);
    // Half sizes written with the top bit set, which the register drops.
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20, 1'b0, 1'b0);
    run_phase(32'h0003_0000, 32'h0003_0000, 32'h0003_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 100, 1'b1, 1'b0);
    run_phase(32'h0000_199A, $urandom_range(0, 32'h0004_0000), 32'h0000_8000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 100, 1'b0, 1'b0);
    run_phase($urandom_range(0, 32'h0003_0000), $urandom_range(0, 32'h0003_0000),
              $urandom_range(0, 32'h0003_0000), $urandom, $urandom, $urandom,
              150, 1'b1, 1'b0);
    run_phase($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 30, 1'b1, 1'b0);
    run_phase($urandom_range(32'h0000_4000, 32'h0002_0000),
              $urandom_range(32'h0000_4000, 32'h0002_0000),
              $urandom_range(32'h0000_4000, 32'h0002_0000),
              32'h0, 32'h0, 32'h0, 150, 1'b1, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
